### src/b64enc_pkg.sv
// shared types, constants and the sextet-to-ascii mapping of the base64 stream encoder
package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] CharUpperA = 7'd65;
  localparam logic [6:0] CharLowerA = 7'd97;
  localparam logic [6:0] CharZero   = 7'd48;
  localparam logic [6:0] CharPlus   = 7'd43;
  localparam logic [6:0] CharSlash  = 7'd47;

  localparam logic [5:0] SextetLowerBase = 6'd26;
  localparam logic [5:0] SextetDigitBase = 6'd52;
  localparam logic [5:0] SextetPlus      = 6'd62;

  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2,
    PhaseSpare  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [5:0] s0;
    logic [5:0] s1;
    logic       two;
    logic       fin;
  } entry_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < SextetLowerBase) begin
      r = CharUpperA + {1'b0, v};
    end else if (v < SextetDigitBase) begin
      r = CharLowerA + {1'b0, v - SextetLowerBase};
    end else if (v < SextetPlus) begin
      r = CharZero + {1'b0, v - SextetDigitBase};
    end else if (v == SextetPlus) begin
      r = CharPlus;
    end else begin
      r = CharSlash;
    end
    return r;
  endfunction

endpackage

### src/base64_stream_encoder_core.sv
// base64 stream encoder top level: front end, queue and character back end
// path: an accepted byte is registered in the queue, then in the back end register
// throughput: one character per cycle while pop is held and the queue holds data, so
// bytes yielding two characters take longer; the single character output port sets the rate
// the queue between front and back absorbs stalls on the result side
// reset: asynchronous active low, clears phase, leftover bits, queue and output state
module base64_stream_encoder_core #(
  parameter int unsigned QDepth = b64enc_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] code_char_o,
  output logic       last_of_run_o,
  output logic       end_of_message_o
);
  import b64enc_pkg::*;

  entry_t f_entry, q_entry;
  logic   accept, q_empty, q_pop;

  assign accept = push && !full;

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .entry_o      (f_entry)
  );

  b64enc_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (f_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_entry),
    .empty_o (q_empty)
  );

  b64enc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .entry_i          (q_entry),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .pop              (pop),
    .empty            (empty),
    .code_char_o      (code_char_o),
    .last_of_run_o    (last_of_run_o),
    .end_of_message_o (end_of_message_o)
  );

endmodule

### src/b64enc_front.sv
// front end: takes a byte, splits it into sextets and tracks the group phase
module b64enc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  output b64enc_pkg::entry_t  entry_o
);
  import b64enc_pkg::*;

  phase_e     phase_q, phase_d;
  logic [5:0] left_q, left_d;

  always_comb begin
    entry_o     = '0;
    entry_o.fin = final_byte_i;
    phase_d     = phase_q;
    left_d      = left_q;
    unique case (phase_q)
      PhaseSecond: begin
        entry_o.s0 = left_q | {2'b00, data_byte_i[7:4]};
        left_d     = {data_byte_i[3:0], 2'b00};
        phase_d    = PhaseThird;
      end
      PhaseThird: begin
        entry_o.s0  = left_q | {4'b0000, data_byte_i[7:6]};
        entry_o.s1  = data_byte_i[5:0];
        entry_o.two = 1'b1;
        left_d      = '0;
        phase_d     = PhaseFirst;
      end
      default: begin
        entry_o.s0 = data_byte_i[7:2];
        left_d     = {data_byte_i[1:0], 4'b0000};
        phase_d    = PhaseSecond;
      end
    endcase
    if (final_byte_i) begin
      if (phase_d != PhaseFirst) begin
        entry_o.s1  = left_d;
        entry_o.two = 1'b1;
      end
      phase_d = PhaseFirst;
      left_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      left_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

### src/b64enc_fifo.sv
// short queue of sextet groups between front and back
module b64enc_fifo #(
  parameter int unsigned Depth = b64enc_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64enc_pkg::entry_t  wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output b64enc_pkg::entry_t  rdata_o,
  output logic                empty_o
);
  import b64enc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/b64enc_back.sv
// back end: holds one sextet group and hands out its characters one beat at a time
module b64enc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64enc_pkg::entry_t  entry_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  input  logic                pop,
  output logic                empty,
  output logic [6:0]          code_char_o,
  output logic                last_of_run_o,
  output logic                end_of_message_o
);
  import b64enc_pkg::*;

  entry_t ent_q;
  logic   valid_q;
  logic   sel_q;
  logic   done, take, adv;

  assign empty = !valid_q;
  assign done  = !ent_q.two || sel_q;
  assign take  = pop && valid_q;
  assign adv   = !valid_q || (take && done);
  assign q_pop_o = adv && !q_empty_i;

  assign code_char_o      = sextet_char(sel_q ? ent_q.s1 : ent_q.s0);
  assign last_of_run_o    = done;
  assign end_of_message_o = done && ent_q.fin;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (take && !done) begin
      sel_q <= 1'b1;
    end else if (adv) begin
      valid_q <= !q_empty_i;
      sel_q   <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_sel_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && sel_q |-> ent_q.two)
    else $error("second character selected on a one-character group");
  a_eom_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && end_of_message_o |-> last_of_run_o)
    else $error("end of message without end of run");
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !sel_q && ent_q.two |=> valid_q && sel_q)
    else $error("second character of a group lost");
`endif

endmodule

### bench/testbench.sv
// testbench for the base64 stream encoder core: byte messages driven through the queue ports
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import b64enc_pkg::*;

  localparam int unsigned ItemTarget = 1600;
  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAt     = 600;
  localparam int unsigned DrainAt    = 800;

  typedef struct {
    logic [7:0]  data;
    logic        fin;
    int unsigned gap;
    logic        drain;
  } byte_beat_t;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
    logic       eom;
  } char_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte_i = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [6:0] code_char_o;
  logic       last_of_run_o;
  logic       end_of_message_o;

  byte_beat_t  pending_bytes [$];
  char_beat_t  expected_chars [$];
  phase_e      enc_phase = PhaseFirst;
  logic [5:0]  carry_bits = '0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned chars_seen = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  logic        held = 1'b0;
  int unsigned idle_cycles = 0;

  base64_stream_encoder_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .final_byte_i     (final_byte_i),
    .empty            (empty),
    .pop              (pop),
    .code_char_o      (code_char_o),
    .last_of_run_o    (last_of_run_o),
    .end_of_message_o (end_of_message_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
    if (v < 6'd26) return CharUpperA + {1'b0, v};
    if (v < 6'd52) return CharLowerA + {1'b0, v - 6'd26};
    if (v < 6'd62) return CharZero + {1'b0, v - 6'd52};
    if (v == 6'd62) return CharPlus;
    return CharSlash;
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    phase_e     p;
    logic [5:0] left;
    logic [5:0] sx [3];
    int         n;
    char_beat_t c;
    p = enc_phase;
    left = carry_bits;
    n = 0;
    if (p == PhaseSpare) begin
      p = PhaseFirst;
      left = '0;
    end
    case (p)
      PhaseFirst: begin
        sx[0] = b[7:2];
        left = {b[1:0], 4'b0000};
        p = PhaseSecond;
        n = 1;
      end
      PhaseSecond: begin
        sx[0] = left | {2'b00, b[7:4]};
        left = {b[3:0], 2'b00};
        p = PhaseThird;
        n = 1;
      end
      default: begin
        sx[0] = left | {4'b0000, b[7:6]};
        sx[1] = b[5:0];
        left = '0;
        p = PhaseFirst;
        n = 2;
      end
    endcase
    // flush of the partial sextet on the last byte
    if (fin) begin
      if (p != PhaseFirst) begin
        sx[n] = left;
        n++;
      end
      p = PhaseFirst;
      left = '0;
    end
    enc_phase = p;
    carry_bits = left;
    for (int i = 0; i < n; i++) begin
      c.code = sextet_to_ascii(sx[i]);
      c.last = (i == n - 1);
      c.eom  = (i == n - 1) && fin;
      expected_chars = {expected_chars, c};
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin, input logic drain);
    byte_beat_t it;
    it.data  = b;
    it.fin   = fin;
    it.drain = drain;
    // stretches of back-to-back bytes
    it.gap   = ((pending_bytes.size() / 100) % 4 == 1) ? 0 : $urandom_range(0, 5);
    pending_bytes = {pending_bytes, it};
  endtask

  // driver
  always @(posedge clk_i) begin
    logic nxt_push;
    if (rst_ni) begin
      nxt_push = push;
      if (push && !full) begin
        encode_byte(data_byte_i, final_byte_i);
        bytes_sent++;
        void'(pending_bytes.pop_front());
        if (pending_bytes.size() > 0) tx_gap = pending_bytes[0].gap;
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_bytes.size() > 0) begin
          if (!pending_bytes[0].drain || expected_chars.size() == 0) begin
            data_byte_i  <= pending_bytes[0].data;
            final_byte_i <= pending_bytes[0].fin;
            nxt_push = 1'b1;
          end
        end
      end
      push <= nxt_push;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    char_beat_t want;
    logic       nxt_pop;
    if (rst_ni) begin
      if (pop && !empty) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual code %h", $time, code_char_o);
        end else begin
          want = expected_chars.pop_front();
          if (code_char_o !== want.code) begin
            errors++;
            $display("%0t: code_char expected %h actual %h", $time, want.code, code_char_o);
          end
          if (last_of_run_o !== want.last) begin
            errors++;
            $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                     last_of_run_o);
          end
          if (end_of_message_o !== want.eom) begin
            errors++;
            $display("%0t: end_of_message expected %b actual %b", $time, want.eom,
                     end_of_message_o);
          end
        end
        rx_gap = ((chars_seen / 150) % 4 == 2) ? 0 : $urandom_range(0, 5);
        if (!held && chars_seen == HoldAt) begin
          held = 1'b1;
          hold_left = HoldCycles;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_pop = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        nxt_pop = 1'b0;
      end else begin
        nxt_pop = 1'b1;
      end
      pop <= nxt_pop;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("base64_stream_encoder_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned len;
    logic        drain_set;
    drain_set = 1'b0;
    // single-byte messages, flush from the first phase
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hff, 1'b1, 1'b0);
    // two-byte messages, flush from the second phase
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b1, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    // full groups ending on the third phase, no flush
    queue_byte(8'h69, 1'b0, 1'b0);
    queue_byte(8'hb7, 1'b0, 1'b0);
    queue_byte(8'h1d, 1'b1, 1'b0);
    queue_byte(8'hfb, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'hbf, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b1, 1'b0);
    // a four-byte message whose first three bytes give digits
    queue_byte(8'hd3, 1'b0, 1'b0);
    queue_byte(8'h5d, 1'b0, 1'b0);
    queue_byte(8'hb7, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b1, 1'b0);
    while (pending_bytes.size() < ItemTarget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        queue_byte(8'($urandom_range(0, 255)), i == len - 1,
                   !drain_set && i == 0 && pending_bytes.size() >= DrainAt);
        if (pending_bytes[$].drain) drain_set = 1'b1;
      end
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("base64_stream_encoder_core: match");
    end else begin
      $display("base64_stream_encoder_core: mismatch");
    end
    $finish;
  end

endmodule
